[rtl/euler_to_quaternion_assert.svh]
// Assertion macros for the euler_to_quaternion checker.
// Needs a signal named clock and a signal named reset in the scope of use.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH
// Checked outside reset only.
`define E2Q_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Also checked while reset is high.
`define E2Q_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

[rtl/e2q_pkg.sv]
// Types, constants and helper functions for the Euler to quaternion converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;
   localparam int WORK_BITS    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 32;
   localparam int CW           = 34;
   localparam int OUT_BITS     = 16;
   localparam logic [32:0] PI_Q30   = 33'd3373259426;
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;

   typedef logic signed [CW-1:0] work_type;
   typedef logic signed [OUT_BITS-1:0] out_type;

   function automatic work_type atan_at(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'h3243F6A8;  1:  v = 32'h1DAC6705;  2:  v = 32'h0FADBAFC;
         3:  v = 32'h07F56EA6;  4:  v = 32'h03FEAB76;  5:  v = 32'h01FFD55B;
         6:  v = 32'h00FFFAAA;  7:  v = 32'h007FFF55;  8:  v = 32'h003FFFEA;
         9:  v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
         18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
         21: v = 32'h000001FF;  22: v = 32'h000000FF;  23: v = 32'h0000007F;
         24: v = 32'h0000003F;  25: v = 32'h0000001F;  26: v = 32'h0000000F;
         27: v = 32'h00000008;  28: v = 32'h00000004;  29: v = 32'h00000002;
         default: v = 32'h0;
      endcase
      return work_type'({2'b00, v});
   endfunction

   // Q30 product, rounded half up
   function automatic work_type qmul(input work_type p, input work_type q);
      logic signed [2*CW-1:0] pr;
      pr = p * q;
      pr = pr + (2*CW)'(64'sd1 <<< (WORK_BITS - 1));
      pr = pr >>> WORK_BITS;
      return pr[CW-1:0];
   endfunction
endpackage
`default_nettype wire

[rtl/e2q_req_if.sv]
// Input channel: three binary angles with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface e2q_req_if #(parameter int ANGLE_BITS = 16);
   logic valid;
   logic ready;
   logic signed [ANGLE_BITS-1:0] roll_angle;
   logic signed [ANGLE_BITS-1:0] pitch_angle;
   logic signed [ANGLE_BITS-1:0] yaw_angle;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface
`default_nettype wire

[rtl/e2q_rsp_if.sv]
// Result channel: quaternion components in Q2.14 with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface e2q_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] q_scalar;
   logic signed [15:0] q_x;
   logic signed [15:0] q_y;
   logic signed [15:0] q_z;
   modport source (output valid, q_scalar, q_x, q_y, q_z, input ready);
   modport sink (input valid, q_scalar, q_x, q_y, q_z, output ready);
endinterface
`default_nettype wire

[rtl/euler_to_quaternion.sv]
// Stages from accepted transaction to result valid: angle scaling, 30 CORDIC steps,
// products, 32 square-root steps, FRAC_BITS+2 divider steps. Throughput: one
// transaction per cycle; each stage moves on when it is empty or its successor moves,
// so bubbles close up under stall.
// Reset (synchronous, active high) clears all stage valid bits; no data reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   e2q_req_if.sink   req_if,
   e2q_rsp_if.source rsp_if
);
   import e2q_pkg::*;

   localparam int QB  = FRAC_BITS + 2;
   localparam int DW  = FRAC_BITS + 36;
   localparam int ST_P1 = 2 + CORDIC_STEPS;
   localparam int ST_P3 = ST_P1 + 2;
   localparam int ST_Q1 = ST_P3 + 1;
   localparam int ST_S0 = ST_Q1 + 2;
   localparam int ST_D0 = ST_S0 + SQRT_STEPS + 1;
   localparam int NST   = ST_D0 + QB + 2;
   localparam int EC    = ST_D0 - ST_P3;
   localparam int ZS    = WORK_BITS - FRAC_BITS;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   logic [NST-1:0] v_ff, v_in;
   logic [NST:0]   en;

   always_comb begin
      en[NST] = rsp_if.ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = {v_ff[NST-2:0], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   assign req_if.ready = en[0];
   assign rsp_if.valid = v_ff[NST-1];

   // angle register, then half angle in Q30 (index 0 roll, 1 pitch, 2 yaw)
   logic signed [ANGLE_BITS-1:0] ang_ff [3];
   logic signed [ANGLE_BITS+32:0] zp [3];
   localparam logic signed [ANGLE_BITS+32:0] ZRND = (ANGLE_BITS+33)'(1) <<< (ANGLE_BITS-1);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ang_ff[0] <= req_if.roll_angle;
         ang_ff[1] <= req_if.pitch_angle;
         ang_ff[2] <= req_if.yaw_angle;
      end
   end

   work_type cx_ff [CORDIC_STEPS+1][3];
   work_type cy_ff [CORDIC_STEPS+1][3];
   work_type cz_ff [CORDIC_STEPS+1][3];
   work_type cx_in [CORDIC_STEPS][3];
   work_type cy_in [CORDIC_STEPS][3];
   work_type cz_in [CORDIC_STEPS][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         zp[j] = ang_ff[j] * $signed({1'b0, PI_Q30}) + ZRND;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!cz_ff[i][j][CW-1]) begin
               cx_in[i][j] = cx_ff[i][j] - (cy_ff[i][j] >>> i);
               cy_in[i][j] = cy_ff[i][j] + (cx_ff[i][j] >>> i);
               cz_in[i][j] = cz_ff[i][j] - atan_at(i);
            end else begin
               cx_in[i][j] = cx_ff[i][j] + (cy_ff[i][j] >>> i);
               cy_in[i][j] = cy_ff[i][j] - (cx_ff[i][j] >>> i);
               cz_in[i][j] = cz_ff[i][j] + atan_at(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int j = 0; j < 3; j++) begin
            cx_ff[0][j] <= work_type'({2'b00, GAIN_Q30});
            cy_ff[0][j] <= '0;
            cz_ff[0][j] <= CW'(zp[j] >>> ANGLE_BITS);
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (en[2+i]) begin
            cx_ff[i+1] <= cx_in[i];
            cy_ff[i+1] <= cy_in[i];
            cz_ff[i+1] <= cz_in[i];
         end
      end
   end

   // sine/cosine products
   work_type cc_ff, cs_ff, ss_ff, sc_ff, ct_ff, st_ff;
   work_type m_ff [8];
   work_type e_ff [EC][4];
   logic [63:0] sq_ff [4];
   logic [63:0] ps_ff [2];
   logic signed [2*CW-1:0] sqf [4];

   always_comb begin
      for (int j = 0; j < 4; j++) sqf[j] = e_ff[0][j] * e_ff[0][j];
   end

   always_ff @(posedge clock) begin
      if (en[ST_P1]) begin
         cc_ff <= qmul(cx_ff[CORDIC_STEPS][0], cx_ff[CORDIC_STEPS][2]);
         cs_ff <= qmul(cx_ff[CORDIC_STEPS][0], cy_ff[CORDIC_STEPS][2]);
         ss_ff <= qmul(cy_ff[CORDIC_STEPS][0], cy_ff[CORDIC_STEPS][2]);
         sc_ff <= qmul(cy_ff[CORDIC_STEPS][0], cx_ff[CORDIC_STEPS][2]);
         ct_ff <= cx_ff[CORDIC_STEPS][1];
         st_ff <= cy_ff[CORDIC_STEPS][1];
      end
      if (en[ST_P1+1]) begin
         m_ff[0] <= qmul(cc_ff, ct_ff);
         m_ff[1] <= qmul(ss_ff, st_ff);
         m_ff[2] <= qmul(sc_ff, ct_ff);
         m_ff[3] <= qmul(cs_ff, st_ff);
         m_ff[4] <= qmul(cc_ff, st_ff);
         m_ff[5] <= qmul(ss_ff, ct_ff);
         m_ff[6] <= qmul(cs_ff, ct_ff);
         m_ff[7] <= qmul(sc_ff, st_ff);
      end
      if (en[ST_P3]) begin
         e_ff[0][0] <= m_ff[0] + m_ff[1];
         e_ff[0][1] <= m_ff[2] - m_ff[3];
         e_ff[0][2] <= m_ff[4] + m_ff[5];
         e_ff[0][3] <= m_ff[6] - m_ff[7];
      end
      for (int m = 1; m < EC; m++) begin
         if (en[ST_P3+m]) e_ff[m] <= e_ff[m-1];
      end
      if (en[ST_Q1]) begin
         for (int j = 0; j < 4; j++) sq_ff[j] <= sqf[j][63:0];
      end
      if (en[ST_Q1+1]) begin
         ps_ff[0] <= sq_ff[0] + sq_ff[1];
         ps_ff[1] <= sq_ff[2] + sq_ff[3];
      end
   end

   // integer square root, one result bit per stage
   logic [63:0] sv_ff [SQRT_STEPS+1];
   logic [63:0] sr_ff [SQRT_STEPS+1];
   logic [63:0] sv_in [SQRT_STEPS];
   logic [63:0] sr_in [SQRT_STEPS];
   logic [64:0] strial;

   always_comb begin
      strial = '0;
      for (int s = 0; s < SQRT_STEPS; s++) begin
         strial = {1'b0, sr_ff[s]} + {1'b0, 64'd1 << (62 - 2*s)};
         if ({1'b0, sv_ff[s]} >= strial) begin
            sv_in[s] = sv_ff[s] - strial[63:0];
            sr_in[s] = (sr_ff[s] >> 1) + (64'd1 << (62 - 2*s));
         end else begin
            sv_in[s] = sv_ff[s];
            sr_in[s] = sr_ff[s] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S0]) begin
         sv_ff[0] <= ps_ff[0] + ps_ff[1];
         sr_ff[0] <= '0;
      end
      for (int s = 0; s < SQRT_STEPS; s++) begin
         if (en[ST_S0+1+s]) begin
            sv_ff[s+1] <= sv_in[s];
            sr_ff[s+1] <= sr_in[s];
         end
      end
   end

   // restoring divider on |e| * 2^FRAC_BITS + len/2
   logic [31:0]  len;
   logic [DW-1:0] dr_ff [QB+1][4];
   logic [QB-1:0] dq_ff [QB+1][4];
   logic [3:0]    dn_ff [QB+1];
   logic [31:0]   dl_ff [QB+1];
   out_type       dz_ff [QB+1][4];
   logic [DW-1:0] dr_in [QB][4];
   logic [QB-1:0] dq_in [QB][4];
   logic [CW-1:0] mag [4];
   logic signed [CW:0] zr [4];
   out_type       zo [4];
   logic [DW-1:0] dsub;

   assign len = sr_ff[SQRT_STEPS][31:0];

   always_comb begin
      dsub = '0;
      for (int j = 0; j < 4; j++) begin
         mag[j] = e_ff[EC-1][j][CW-1] ? CW'(-e_ff[EC-1][j]) : CW'(e_ff[EC-1][j]);
         // unnormalized path, used only when the length is zero
         if (ZS > 0) begin
            zr[j] = $signed({e_ff[EC-1][j][CW-1], e_ff[EC-1][j]}
                     + ((CW+1)'(1) <<< (ZS > 0 ? ZS - 1 : 0))) >>> ZS;
         end else begin
            zr[j] = {e_ff[EC-1][j][CW-1], e_ff[EC-1][j]};
         end
         if (64'(zr[j]) > ONE) zo[j] = out_type'(ONE[OUT_BITS-1:0]);
         else if (64'(zr[j]) < -ONE) zo[j] = out_type'(-ONE);
         else zo[j] = zr[j][OUT_BITS-1:0];
      end
      for (int d = 0; d < QB; d++) begin
         for (int j = 0; j < 4; j++) begin
            dsub = DW'(dl_ff[d]) << (QB - 1 - d);
            if (dr_ff[d][j] >= dsub) begin
               dr_in[d][j] = dr_ff[d][j] - dsub;
               dq_in[d][j] = dq_ff[d][j] | (QB'(1) << (QB - 1 - d));
            end else begin
               dr_in[d][j] = dr_ff[d][j];
               dq_in[d][j] = dq_ff[d][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_D0]) begin
         for (int j = 0; j < 4; j++) begin
            dr_ff[0][j] <= (DW'(mag[j]) << FRAC_BITS) + DW'(len >> 1);
            dq_ff[0][j] <= '0;
            dn_ff[0][j] <= e_ff[EC-1][j][CW-1];
            dz_ff[0][j] <= zo[j];
         end
         dl_ff[0] <= len;
      end
      for (int d = 0; d < QB; d++) begin
         if (en[ST_D0+1+d]) begin
            dr_ff[d+1] <= dr_in[d];
            dq_ff[d+1] <= dq_in[d];
            dn_ff[d+1] <= dn_ff[d];
            dz_ff[d+1] <= dz_ff[d];
            dl_ff[d+1] <= dl_ff[d];
         end
      end
   end

   // output register: clamp, sign, pick zero-length path
   out_type o_ff [4];
   out_type o_in [4];
   logic signed [63:0] qv [4];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         qv[j] = 64'(dq_ff[QB][j]);
         if (qv[j] > ONE) qv[j] = ONE;
         if (dn_ff[QB][j]) qv[j] = -qv[j];
         o_in[j] = (dl_ff[QB] == '0) ? dz_ff[QB][j] : qv[j][OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) o_ff <= o_in;
   end

   assign rsp_if.q_scalar = o_ff[0];
   assign rsp_if.q_x      = o_ff[1];
   assign rsp_if.q_y      = o_ff[2];
   assign rsp_if.q_z      = o_ff[3];
endmodule
`default_nettype wire

[rtl/e2q_checker.sv]
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends on euler_to_quaternion_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
module e2q_checker #(
   parameter int FRAC_BITS = 14
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_data
);
   `include "euler_to_quaternion_assert.svh"

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic seen_ff, seen_in;
   logic in_range;

   assign seen_in = seen_ff || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // only meaningful while one fits the 16-bit result
   always_comb begin
      in_range = 1'b1;
      if (FRAC_BITS < 15) begin
         for (int j = 0; j < 4; j++) begin
            if (32'($signed(rsp_data[16*j +: 16])) > ONE
                || 32'($signed(rsp_data[16*j +: 16])) < -ONE) in_range = 1'b0;
         end
      end
   end

   `E2Q_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped or changed under stall")
   `E2Q_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "result valid straight after reset")
   `E2Q_ASSERT(a_no_invent, rsp_valid |-> seen_ff, "result with no transaction accepted")
   `E2Q_ASSERT(a_range, rsp_valid |-> in_range, "component beyond plus or minus one")
endmodule

bind euler_to_quaternion e2q_checker #(.FRAC_BITS(FRAC_BITS)) u_e2q_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_data ({rsp_if.q_z, rsp_if.q_y, rsp_if.q_x, rsp_if.q_scalar})
);
`default_nettype wire

[verif/euler_to_quaternion_checker.sv]
// Checker for euler_to_quaternion: watches both channels, predicts each quaternion
// in its own bit-exact fixed-point model and compares the results in order.
// Depends on e2q_req_if and e2q_rsp_if.
`timescale 1ns / 1ps
module euler_to_quaternion_checker (
   input  logic clock,
   input  logic reset,
   e2q_req_if   req,
   e2q_rsp_if   rsp,
   output int   errors,
   output int   pending
);
   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_t;

   localparam longint HALF_PI_SCALE = 64'sd3373259426;
   localparam longint CORDIC_GAIN   = 64'sd652032874;
   localparam int     FRAC          = 14;

   localparam longint ATAN_TBL [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   quat_t quat_fifo[$];

   // sine and cosine of half the binary angle, Q30
   task automatic half_sincos(input logic signed [15:0] ang,
                              output longint s, output longint c);
      longint a, z, x, y, dx, dy;
      a = ang;
      z = (a * HALF_PI_SCALE + 64'sd32768) >>> 16;
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_TBL[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_TBL[i];
         end
      end
      s = y;
      c = x;
   endtask

   function automatic longint mul_q30(input longint p, input longint q);
      return (p * q + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] scale_component(input longint e,
                                                          input longint unsigned len);
      longint one, r;
      longint unsigned mag, q;
      one = 64'sd1 << FRAC;
      if (len == 0) begin
         r = (e + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
      end else begin
         mag = (e < 0) ? -e : e;
         q = ((mag << FRAC) + (len >> 1)) / len;
         if (q > one) q = one;
         r = (e < 0) ? -longint'(q) : longint'(q);
      end
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
   endfunction

   task automatic predict_quat(input logic signed [15:0] roll, pitch, yaw,
                               output quat_t qt);
      longint sr, cr, sp, cp, sy, cy, cc, cs, ss, sc, e0, ex, ey, ez;
      longint unsigned l2, len;
      half_sincos(roll, sr, cr);
      half_sincos(pitch, sp, cp);
      half_sincos(yaw, sy, cy);
      cc = mul_q30(cr, cy);
      cs = mul_q30(cr, sy);
      ss = mul_q30(sr, sy);
      sc = mul_q30(sr, cy);
      e0 = mul_q30(cc, cp) + mul_q30(ss, sp);
      ex = mul_q30(sc, cp) - mul_q30(cs, sp);
      ey = mul_q30(cc, sp) + mul_q30(ss, cp);
      ez = mul_q30(cs, cp) - mul_q30(sc, sp);
      l2 = longint'(e0 * e0) + longint'(ex * ex) + longint'(ey * ey) + longint'(ez * ez);
      len = root_floor(l2);
      qt.w = scale_component(e0, len);
      qt.x = scale_component(ex, len);
      qt.y = scale_component(ey, len);
      qt.z = scale_component(ez, len);
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      quat_t qt, got;
      if (!reset) begin
         if (req.valid && req.ready) begin
            predict_quat(req.roll_angle, req.pitch_angle, req.yaw_angle, qt);
            quat_fifo.push_back(qt);
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.q_scalar, rsp.q_x, rsp.q_y, rsp.q_z};
            if (quat_fifo.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               qt = quat_fifo.pop_front();
               if (got.w !== qt.w) begin
                  $error("q_scalar: expected %0d, got %0d", qt.w, got.w); errors++;
               end
               if (got.x !== qt.x) begin
                  $error("q_x: expected %0d, got %0d", qt.x, got.x); errors++;
               end
               if (got.y !== qt.y) begin
                  $error("q_y: expected %0d, got %0d", qt.y, got.y); errors++;
               end
               if (got.z !== qt.z) begin
                  $error("q_z: expected %0d, got %0d", qt.z, got.z); errors++;
               end
            end
         end
         pending <= quat_fifo.size();
      end
   end
endmodule

[verif/euler_to_quaternion_tb.sv]
// Top of the euler_to_quaternion testbench: clock, reset, angle stimulus and
// result back-pressure. Depends on the RTL, its interfaces and the checker.
`timescale 1ns / 1ps
module euler_to_quaternion_tb;
   logic clock = 0;
   logic reset = 1;
   int   errors, pending;
   int   n_sent = 0;
   logic quiet_in = 0, quiet_out = 0;

   e2q_req_if #(.ANGLE_BITS(16)) req_ch();
   e2q_rsp_if rsp_ch();

   euler_to_quaternion #(.ANGLE_BITS(16), .FRAC_BITS(14)) uut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch));

   euler_to_quaternion_checker chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .errors(errors), .pending(pending));

   always #1 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.roll_angle = 0;
      req_ch.pitch_angle = 0;
      req_ch.yaw_angle = 0;
      rsp_ch.ready = 0;
   end

   // Receiver: random stalls, a quiet stretch, and one long hold-off to fill the pipe
   initial begin
      int cyc;
      cyc = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cyc >= 300 && cyc < 700)
            rsp_ch.ready <= 0;
         else if (cyc >= 1000 && cyc < 1600)
            rsp_ch.ready <= 1;
         else
            rsp_ch.ready <= ($urandom_range(99) >= 12);
         cyc++;
         @(posedge clock);
      end
   end

   task automatic send_angles(input logic signed [15:0] r, p, y);
      if (!quiet_in && $urandom_range(99) < 12) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.roll_angle <= r;
      req_ch.pitch_angle <= p;
      req_ch.yaw_angle <= y;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
   endtask

   function automatic logic signed [15:0] pick_angle();
      logic signed [15:0] edges [8] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh4000,
                                        -16'sh4000, 16'sh0001, -16'sh0001, 16'sh2000};
      if ($urandom_range(99) < 70) return 16'($urandom_range(16'hFFFF));
      return edges[$urandom_range(7)] + $signed(16'($urandom_range(8))) - 16'sd4;
   endfunction

   initial begin
      logic signed [15:0] dir_set [16][3] = '{
         '{0, 0, 0}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '{-16'sh8000, -16'sh8000, -16'sh8000},
         '{0, 16'sh4000, 0}, '{0, -16'sh4000, 0}, '{16'sh7FFF, 0, 0}, '{0, -16'sh8000, 0},
         '{0, 0, 16'sh7FFF}, '{-1, -1, -1}, '{1, 1, 1}, '{16'sh4000, -16'sh4000, 16'sh2000},
         '{-16'sh8000, 16'sh4000, 16'sh7FFF}, '{16'sh5555, -16'sh5556, 16'sh2AAA},
         '{-16'sh4000, 16'sh4000, -16'sh4000}, '{16'sh0001, 16'sh7FFE, -16'sh7FFF},
         '{16'sh2000, 16'sh2000, -16'sh2000}};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir_set[i]) send_angles(dir_set[i][0], dir_set[i][1], dir_set[i][2]);
      for (int i = 0; i < 1350; i++) begin
         quiet_in = (i >= 400 && i < 700);
         if (i == 900) begin
            // drain fully before carrying on
            req_ch.valid <= 0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
